// ----- rtl/dtmr_pkg.sv -----
// Shared constants, register codes and a color helper for the diamond tile map renderer.
package dtmr_pkg;

    // Default sizes of the column store and the palette.
    localparam int DEF_MAX_MAP_SIDE  = 1024;
    localparam int DEF_PALETTE_DEPTH = 256;

    // Field widths.
    localparam int CFG_W   = 11;
    localparam int TYPE_W  = 8;
    localparam int COLOR_W = 24;
    localparam int COORD_W = 11;
    localparam int CNT_W   = 9;
    localparam int IDX_W   = 2;

    // Stream widths.
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 48;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] REG_MAP_WIDTH  = 2'd0;
    localparam logic [IDX_W-1:0] REG_MAP_HEIGHT = 2'd1;
    localparam logic [IDX_W-1:0] REG_TYPE_COUNT = 2'd2;

    // Input command codes.
    localparam logic CMD_TILE  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // Color of a tile whose terrain type is not valid.
    localparam logic [COLOR_W-1:0] RED_COLOR = 24'hFF0000;

    // Per-channel mean of four colors, truncated.
    function automatic logic [COLOR_W-1:0] mean4(
        input logic [COLOR_W-1:0] a,
        input logic [COLOR_W-1:0] b,
        input logic [COLOR_W-1:0] c,
        input logic [COLOR_W-1:0] d
    );
        logic [COLOR_W-1:0] res;
        logic [9:0]         sum;
        res = '0;
        for (int i = 0; i < 3; i++) begin
            sum = 10'(a[8*i +: 8]) + 10'(b[8*i +: 8]) + 10'(c[8*i +: 8]) + 10'(d[8*i +: 8]);
            res[8*i +: 8] = sum[9:2];
        end
        return res;
    endfunction

endpackage

// ----- rtl/diamond_tile_map_renderer.sv -----
// Diamond tile map renderer: palette, column store and one- or two-beat pixel output.
//
// Usage: terrain types arrive on the s_ stream, column by column (x outer,
// y inner); palette entries are loaded through the same stream with tuser = 1.
// Each tile gives one pixel beat with its own color at (x+y, x+h-y-1). Where
// x > 0 and y > 0 a second beat follows, one pixel to the left, holding the
// truncated per-channel mean of the 2x2 neighborhood; tlast marks the final
// beat of each tile. Palette writes give no beat.
// The output register gives one beat per cycle while the receiver is ready;
// while a tile's mean beat is pending, the next tile waits in the color stage.
// Palette writes do not enter the color stage. The palette and column store
// reads are registered into the color stage, and the tile color and mean into
// the output register.
// Reset clears the tile counters, the neighbor colors and the pipeline; the
// map is 1 x 1 with no valid types until configured. Palette and column store
// hold no reset. A write of map_width or map_height restarts at tile (0, 0).
// When the receiver stalls, the output register holds its beat, the color
// stage holds behind it and s_tready falls until the output register can take it.
module diamond_tile_map_renderer
    import dtmr_pkg::*;
#(
    parameter int MAX_MAP_SIDE  = DEF_MAX_MAP_SIDE,
    parameter int PALETTE_DEPTH = DEF_PALETTE_DEPTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    // Configuration write port.
    input  logic                cfg_we,
    input  logic [IDX_W-1:0]    cfg_index,
    input  logic [CFG_W-1:0]    cfg_data,
    // Input stream.
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // terrain_type[7:0], palette_color[31:8]
    input  logic                s_tuser,   // command[0]
    // Pixel stream.
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // pixel_x[10:0], pixel_y[21:11],
                                           // pixel_value[45:22], zeros[47:46]
    output logic                m_tlast    // last
);

    localparam int IW     = $clog2(MAX_MAP_SIDE);
    localparam int SW_RAW = $clog2(MAX_MAP_SIDE + 1);
    localparam int SW     = (SW_RAW > CFG_W) ? SW_RAW : CFG_W;
    localparam int PAW    = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

    // Saturate a map side to 1 .. MAX_MAP_SIDE.
    function automatic logic [SW-1:0] sat_side(input logic [CFG_W-1:0] v);
        logic [SW-1:0] ext;
        ext = SW'(v);
        if (ext == '0) begin
            return SW'(1);
        end else if (ext > SW'(MAX_MAP_SIDE)) begin
            return SW'(MAX_MAP_SIDE);
        end
        return ext;
    endfunction

    // Input fields.
    logic [TYPE_W-1:0]  s_type;
    logic [COLOR_W-1:0] s_color;
    assign s_type  = s_tdata[TYPE_W-1:0];
    assign s_color = s_tdata[TYPE_W +: COLOR_W];

    // Configuration and position state.
    logic [SW-1:0]    w_sat_reg, h_sat_reg;
    logic [CNT_W-1:0] type_count_reg;
    logic [IW-1:0]    col_reg, col_next;
    logic [IW-1:0]    row_reg, row_next;

    // Color stage.
    logic               st1_valid_reg;
    logic [COORD_W-1:0] st1_px_reg, st1_py_reg;
    logic [IW-1:0]      st1_y_reg;
    logic               st1_bad_reg, st1_mean_reg;
    logic [COLOR_W-1:0] pal_rd_reg, col_rd_reg;
    logic               fwd_hit_reg;
    logic [COLOR_W-1:0] fwd_data_reg;
    logic [COLOR_W-1:0] above_reg, diag_reg;

    // Output register.
    logic               ob_valid_reg, ob_second_reg, ob_last_reg;
    logic [COORD_W-1:0] ob_px_reg, ob_py_reg;
    logic [COLOR_W-1:0] ob_val_reg, ob_mean_reg;

    // Memories.
    logic [COLOR_W-1:0] pal_mem [PALETTE_DEPTH];
    logic [COLOR_W-1:0] col_mem [MAX_MAP_SIDE];

    // Handshake and control terms.
    logic in_acc, tile_acc, pal_we, out_acc, ob_take, st1_move, type_bad;
    logic [COLOR_W-1:0] cur_color, cur_left, cur_mean;
    logic [SW:0]        px_full, py_full;
    logic [SW-1:0]      row_inc, col_inc;

    assign ob_take  = !ob_valid_reg || (m_tready && !ob_second_reg);
    assign st1_move = st1_valid_reg && ob_take;
    assign s_tready = !st1_valid_reg || st1_move;
    assign in_acc   = s_tvalid && s_tready;
    assign tile_acc = in_acc && (s_tuser == CMD_TILE);
    assign pal_we   = in_acc && (s_tuser == CMD_WRITE) && (32'(s_type) < PALETTE_DEPTH);
    assign out_acc  = m_tvalid && m_tready;

    // Type check and pixel coordinates of the tile at the counters.
    assign type_bad = ({1'b0, s_type} >= type_count_reg) || (32'(s_type) >= PALETTE_DEPTH);
    assign px_full  = (SW+1)'(col_reg) + (SW+1)'(row_reg);
    assign py_full  = (SW+1)'(col_reg) + (SW+1)'(h_sat_reg) - (SW+1)'(row_reg) - (SW+1)'(1);

    // Next tile position, column by column with wrap at the end of the map.
    assign row_inc = SW'(row_reg) + SW'(1);
    assign col_inc = SW'(col_reg) + SW'(1);
    always_comb begin
        row_next = row_reg;
        col_next = col_reg;
        if (row_inc >= h_sat_reg) begin
            row_next = '0;
            col_next = (col_inc >= w_sat_reg) ? '0 : col_inc[IW-1:0];
        end else begin
            row_next = row_inc[IW-1:0];
        end
    end

    // Configuration registers and tile counters.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_sat_reg      <= SW'(1);
            h_sat_reg      <= SW'(1);
            type_count_reg <= '0;
            col_reg        <= '0;
            row_reg        <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_MAP_WIDTH: begin
                    w_sat_reg <= sat_side(cfg_data);
                    col_reg   <= '0;
                    row_reg   <= '0;
                end
                REG_MAP_HEIGHT: begin
                    h_sat_reg <= sat_side(cfg_data);
                    col_reg   <= '0;
                    row_reg   <= '0;
                end
                REG_TYPE_COUNT: begin
                    type_count_reg <= cfg_data[CNT_W-1:0];
                end
                default: begin
                end
            endcase
        end else if (tile_acc) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Palette: written by palette beats, read when a tile is accepted.
    always_ff @(posedge aclk) begin
        if (pal_we) begin
            pal_mem[PAW'(s_type)] <= s_color;
        end
        if (tile_acc) begin
            pal_rd_reg <= pal_mem[PAW'(s_type)];
        end
    end

    // Column store: previous column's colors, written as a tile leaves the color stage.
    always_ff @(posedge aclk) begin
        if (st1_move) begin
            col_mem[st1_y_reg] <= cur_color;
        end
        if (tile_acc) begin
            col_rd_reg <= col_mem[row_reg];
        end
    end

    // Color stage control; the forward flag covers a read that meets a write in the same cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
            fwd_hit_reg   <= 1'b0;
            above_reg     <= '0;
            diag_reg      <= '0;
        end else begin
            if (tile_acc) begin
                st1_valid_reg <= 1'b1;
                fwd_hit_reg   <= st1_move && (st1_y_reg == row_reg);
            end else if (st1_move) begin
                st1_valid_reg <= 1'b0;
            end
            if (st1_move) begin
                above_reg <= cur_color;
                diag_reg  <= cur_left;
            end
        end
    end

    // Color stage payload.
    always_ff @(posedge aclk) begin
        if (tile_acc) begin
            st1_px_reg   <= px_full[COORD_W-1:0];
            st1_py_reg   <= py_full[COORD_W-1:0];
            st1_y_reg    <= row_reg;
            st1_bad_reg  <= type_bad;
            st1_mean_reg <= (col_reg != '0) && (row_reg != '0);
            fwd_data_reg <= cur_color;
        end
    end

    // Tile color and neighborhood mean.
    assign cur_color = st1_bad_reg ? RED_COLOR : pal_rd_reg;
    assign cur_left  = fwd_hit_reg ? fwd_data_reg : col_rd_reg;
    assign cur_mean  = mean4(diag_reg, cur_left, above_reg, cur_color);

    // Output register control: color beat, then the mean beat when there is one.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ob_valid_reg  <= 1'b0;
            ob_second_reg <= 1'b0;
        end else if (st1_move) begin
            ob_valid_reg  <= 1'b1;
            ob_second_reg <= st1_mean_reg;
        end else if (out_acc) begin
            ob_valid_reg  <= ob_second_reg;
            ob_second_reg <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge aclk) begin
        if (st1_move) begin
            ob_px_reg   <= st1_px_reg;
            ob_py_reg   <= st1_py_reg;
            ob_val_reg  <= cur_color;
            ob_last_reg <= !st1_mean_reg;
            ob_mean_reg <= cur_mean;
        end else if (out_acc && ob_second_reg) begin
            ob_px_reg   <= ob_px_reg - COORD_W'(1);
            ob_val_reg  <= ob_mean_reg;
            ob_last_reg <= 1'b1;
        end
    end

    assign m_tvalid = ob_valid_reg;
    assign m_tlast  = ob_last_reg;
    assign m_tdata  = {{(M_DATA_W - 2*COORD_W - COLOR_W){1'b0}}, ob_val_reg, ob_py_reg, ob_px_reg};

    // A color beat without tlast is always followed by its mean beat.
    a_mean_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_acc && !m_tlast) |=> (m_tvalid && m_tlast))
        else $error("mean beat missing after color beat");

    // A pending mean beat means the color beat of the same tile is on the port.
    a_second_shown: assert property (@(posedge aclk) disable iff (!aresetn)
        ob_second_reg |-> (m_tvalid && !m_tlast))
        else $error("pending mean beat without its color beat");

    // A stalled color stage keeps its tile.
    a_stage_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (st1_valid_reg && !st1_move) |=> (st1_valid_reg && $stable(st1_y_reg)))
        else $error("color stage lost a tile");

    // The tile counters stay inside the configured map.
    a_pos_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (SW'(row_reg) < h_sat_reg) && (SW'(col_reg) < w_sat_reg))
        else $error("tile counter outside map");

endmodule

// ----- tb/diamond_tile_map_renderer_checker.sv -----
// Checker for the diamond tile map renderer: predicts pixel beats and compares them.
module diamond_tile_map_renderer_checker
    import dtmr_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [IDX_W-1:0]    cfg_index,
    input  logic [CFG_W-1:0]    cfg_data,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // terrain_type[7:0], palette_color[31:8]
    input  logic                s_tuser,   // command[0]
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [M_DATA_W-1:0] m_tdata,   // pixel_x[10:0], pixel_y[21:11],
                                           // pixel_value[45:22], zeros[47:46]
    input  logic                m_tlast,   // last
    output int                  error_count,
    output int                  pending_pixels,
    output int                  pixels_checked
);

    typedef struct {
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic [COLOR_W-1:0] color;
        logic               last;
    } pixel_t;

    // Shadow of the renderer state.
    logic [COLOR_W-1:0] palette_mem [DEF_PALETTE_DEPTH];
    logic [COLOR_W-1:0] prev_column [DEF_MAX_MAP_SIDE];
    logic [COLOR_W-1:0] above_c;
    logic [COLOR_W-1:0] diag_c;
    int unsigned        tile_x;
    int unsigned        tile_y;
    logic [CFG_W-1:0]   width_reg;
    logic [CFG_W-1:0]   height_reg;
    logic [CNT_W-1:0]   types_reg;

    pixel_t expected_pixels [$];

    // Map sides are used saturated to 1 .. MAX_MAP_SIDE.
    function automatic int unsigned side_of(input logic [CFG_W-1:0] v);
        if (v == 0) return 1;
        if (int'(v) > DEF_MAX_MAP_SIDE) return DEF_MAX_MAP_SIDE;
        return 32'(v);
    endfunction

    // Truncated per-channel mean of four colors.
    function automatic logic [COLOR_W-1:0] blend4(input logic [COLOR_W-1:0] a,
                                                  input logic [COLOR_W-1:0] b,
                                                  input logic [COLOR_W-1:0] c,
                                                  input logic [COLOR_W-1:0] d);
        logic [COLOR_W-1:0] res;
        int unsigned        total;
        res = '0;
        for (int ch = 0; ch < 3; ch++) begin
            total = 32'(a[8*ch +: 8]) + 32'(b[8*ch +: 8]) + 32'(c[8*ch +: 8])
                  + 32'(d[8*ch +: 8]);
            res[8*ch +: 8] = 8'(total / 4);
        end
        return res;
    endfunction

    // Works out the pixel beats of one tile and advances the tile position.
    task automatic render_tile(input logic [TYPE_W-1:0] ttype);
        int unsigned        w;
        int unsigned        h;
        int unsigned        x;
        int unsigned        y;
        logic [COLOR_W-1:0] color;
        logic [COLOR_W-1:0] left;
        logic [COLOR_W-1:0] corner;
        pixel_t             pix;
        w = side_of(width_reg);
        h = side_of(height_reg);
        x = (tile_x >= w) ? 0 : tile_x;
        y = (tile_y >= h) ? 0 : tile_y;
        if (CNT_W'(ttype) >= types_reg || int'(ttype) >= DEF_PALETTE_DEPTH)
            color = RED_COLOR;
        else
            color = palette_mem[ttype];
        left   = prev_column[y];
        corner = (y == 0) ? '0 : diag_c;
        pix.col   = COORD_W'(x + y);
        pix.row   = COORD_W'(x + h - y - 1);
        pix.color = color;
        pix.last  = !(x > 0 && y > 0);
        expected_pixels.push_back(pix);
        // The mean pixel sits one column to the left of the tile's own pixel.
        if (x > 0 && y > 0) begin
            pix.col   = COORD_W'(x + y - 1);
            pix.color = blend4(corner, left, above_c, color);
            pix.last  = 1'b1;
            expected_pixels.push_back(pix);
        end
        diag_c         = left;
        prev_column[y] = color;
        above_c        = color;
        y++;
        if (y >= h) begin
            y = 0;
            x++;
            if (x >= w) x = 0;
        end
        tile_x = x;
        tile_y = y;
    endtask

    // Compares one output beat with the oldest expected pixel.
    task automatic check_beat();
        pixel_t pix;
        if (expected_pixels.size() == 0) begin
            $error("pixel beat with nothing expected: x %0d y %0d value %06h",
                   m_tdata[10:0], m_tdata[21:11], m_tdata[45:22]);
            error_count++;
        end else begin
            pix = expected_pixels.pop_front();
            pixels_checked++;
            if (m_tdata[10:0] !== pix.col) begin
                $error("pixel_x: expected %0d, got %0d", pix.col, m_tdata[10:0]);
                error_count++;
            end
            if (m_tdata[21:11] !== pix.row) begin
                $error("pixel_y: expected %0d, got %0d", pix.row, m_tdata[21:11]);
                error_count++;
            end
            if (m_tdata[45:22] !== pix.color) begin
                $error("pixel_value: expected %06h, got %06h", pix.color, m_tdata[45:22]);
                error_count++;
            end
            if (m_tdata[47:46] !== 2'b00) begin
                $error("tdata padding: expected 0, got %0d", m_tdata[47:46]);
                error_count++;
            end
            if (m_tlast !== pix.last) begin
                $error("last: expected %0d, got %0d", pix.last, m_tlast);
                error_count++;
            end
        end
    endtask

    // Follow reset, register writes and both channels at every edge.
    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DEF_PALETTE_DEPTH; i++) palette_mem[i] = '0;
            for (int i = 0; i < DEF_MAX_MAP_SIDE; i++) prev_column[i] = '0;
            above_c    = '0;
            diag_c     = '0;
            tile_x     = 0;
            tile_y     = 0;
            width_reg  = CFG_W'(1);
            height_reg = CFG_W'(1);
            types_reg  = '0;
            expected_pixels.delete();
        end else begin
            if (m_tvalid && m_tready) check_beat();
            if (cfg_we) begin
                case (cfg_index)
                    REG_MAP_WIDTH: begin
                        width_reg = cfg_data;
                        tile_x    = 0;
                        tile_y    = 0;
                    end
                    REG_MAP_HEIGHT: begin
                        height_reg = cfg_data;
                        tile_x     = 0;
                        tile_y     = 0;
                    end
                    REG_TYPE_COUNT: types_reg = cfg_data[CNT_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser == CMD_WRITE) begin
                    if (int'(s_tdata[7:0]) < DEF_PALETTE_DEPTH)
                        palette_mem[s_tdata[7:0]] = s_tdata[31:8];
                end else begin
                    render_tile(s_tdata[7:0]);
                end
            end
        end
        pending_pixels <= expected_pixels.size();
    end

endmodule

// ----- tb/diamond_tile_map_renderer_tb.sv -----
// Testbench top for the diamond tile map renderer: clock, reset, stimulus and verdict.
module diamond_tile_map_renderer_tb;
    import dtmr_pkg::*;

    localparam int QUIET_LIMIT = 600;
    localparam int N_PHASES    = 8;

    logic                aclk;
    logic                aresetn   = 1'b0;
    logic                cfg_we    = 1'b0;
    logic [IDX_W-1:0]    cfg_index = '0;
    logic [CFG_W-1:0]    cfg_data  = '0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata   = '0;   // terrain_type[7:0], palette_color[31:8]
    logic                s_tuser   = 1'b0; // command[0]
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;          // pixel_x[10:0], pixel_y[21:11],
                                           // pixel_value[45:22], zeros[47:46]
    logic                m_tlast;          // last

    int error_count;
    int pending_pixels;
    int pixels_checked;
    int quiet_cycles = 0;
    int n_tiles      = 0;
    int n_loads      = 0;
    bit s_idle_on    = 1'b0;
    bit m_stall_on   = 1'b0;

    // Palette entries written so far; tiles only use these or invalid types.
    bit              loaded [DEF_PALETTE_DEPTH];
    logic [TYPE_W-1:0] loaded_list [$];

    // Map settings per phase: width, height, type count (-1 leaves it), length, idling.
    // Idling: bit 0 lets the sender pause, bit 1 lets the receiver stall.
    int ph_w    [N_PHASES] = '{0, 5,   1, -1,  2047, 3, 1024, 7};
    int ph_h    [N_PHASES] = '{0, 4,   7, -1,  1,    2, 1024, 3};
    int ph_tc   [N_PHASES] = '{0, 256, 17, 128, 511, 1, 200,  64};
    int ph_len  [N_PHASES] = '{20, 80, 30, 25,  50,  50, 30,  70};
    int ph_idle [N_PHASES] = '{3, 3,   1, 2,    3,   2, 3,    0};

    diamond_tile_map_renderer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    diamond_tile_map_renderer_checker chk (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .error_count    (error_count),
        .pending_pixels (pending_pixels),
        .pixels_checked (pixels_checked)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Receiver: ready runs broken by stall bursts while stalling is enabled.
    initial begin
        @(posedge aclk);
        forever begin
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            if (m_stall_on) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge aclk);
            end
        end
    end

    // Watchdog: too long without any beat on either channel ends the run.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offers one input beat, optionally after an idle burst, and waits for it.
    task automatic send_item(input logic cmd, input logic [TYPE_W-1:0] ttype,
                             input logic [COLOR_W-1:0] pcolor);
        if (s_idle_on && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {pcolor, ttype};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (cmd == CMD_WRITE) begin
            n_loads++;
            if (!loaded[ttype]) begin
                loaded[ttype] = 1'b1;
                loaded_list.push_back(ttype);
            end
        end else begin
            n_tiles++;
        end
    endtask

    // Stops the input and waits until every expected pixel has arrived and
    // any palette write still in the pipeline has settled.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_pixels != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input int val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_W'(val);
        @(posedge aclk);
    endtask

    // A negative value leaves that register as it is.
    task automatic program_map(input int w, input int h, input int tc);
        if (w >= 0) write_reg(REG_MAP_WIDTH, w);
        if (h >= 0) write_reg(REG_MAP_HEIGHT, h);
        if (tc >= 0) write_reg(REG_TYPE_COUNT, tc);
        cfg_we <= 1'b0;
    endtask

    // Mostly tiles of loaded types, some invalid types, a few palette loads.
    task automatic random_item(input int tc);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 12)
            send_item(CMD_WRITE, TYPE_W'($urandom), COLOR_W'($urandom));
        else if ((roll < 32 || loaded_list.size() == 0) && tc < DEF_PALETTE_DEPTH)
            send_item(CMD_TILE, TYPE_W'($urandom_range(tc, 255)), COLOR_W'($urandom));
        else if (loaded_list.size() != 0)
            send_item(CMD_TILE, loaded_list[$urandom_range(0, loaded_list.size() - 1)],
                      COLOR_W'($urandom));
        else
            send_item(CMD_WRITE, TYPE_W'($urandom), COLOR_W'($urandom));
    endtask

    initial begin
        int cur_tc;
        int seed_lim;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        s_idle_on  = 1'b1;
        m_stall_on = 1'b1;

        // Out of reset the map is 1 x 1 with no valid type: everything is red.
        send_item(CMD_TILE, 8'd0, 24'h000000);
        send_item(CMD_WRITE, 8'd255, 24'hFFFFFF);
        send_item(CMD_TILE, 8'd255, 24'hFFFFFF);
        wait_idle();

        // A full 3 x 3 frame and its wrap, with black, white and invalid types.
        program_map(3, 3, 4);
        send_item(CMD_WRITE, 8'd0, 24'h000000);
        send_item(CMD_WRITE, 8'd1, 24'hFFFFFF);
        send_item(CMD_WRITE, 8'd2, 24'h80FF01);
        send_item(CMD_WRITE, 8'd3, COLOR_W'($urandom));
        send_item(CMD_TILE, 8'd1, 24'h000000);
        send_item(CMD_TILE, 8'd0, 24'hFFFFFF);
        send_item(CMD_TILE, 8'd3, 24'h000000);
        send_item(CMD_TILE, 8'd2, 24'h000000);
        send_item(CMD_TILE, 8'd4, 24'h000000);
        send_item(CMD_TILE, 8'd1, 24'h000000);
        send_item(CMD_TILE, 8'd255, 24'h000000);
        send_item(CMD_TILE, 8'd1, 24'h000000);
        send_item(CMD_TILE, 8'd0, 24'h000000);
        send_item(CMD_TILE, 8'd1, 24'h000000);
        send_item(CMD_TILE, 8'd2, 24'h000000);

        // Random phases, each under its own map setting.
        for (int p = 0; p < N_PHASES; p++) begin
            wait_idle();
            program_map(ph_w[p], ph_h[p], ph_tc[p]);
            cur_tc     = ph_tc[p];
            s_idle_on  = ph_idle[p][0];
            m_stall_on = ph_idle[p][1];
            seed_lim   = (cur_tc > DEF_PALETTE_DEPTH) ? DEF_PALETTE_DEPTH : cur_tc;
            if (seed_lim > 0) begin
                repeat (4) send_item(CMD_WRITE, TYPE_W'($urandom_range(0, seed_lim - 1)),
                                     COLOR_W'($urandom));
            end
            repeat (ph_len[p]) random_item(cur_tc);
        end

        wait_idle();
        repeat (8) @(posedge aclk);
        $display("Rendered %0d tiles and loaded %0d palette entries over %0d map settings;",
                 n_tiles, n_loads, N_PHASES + 2);
        $display("%0d pixel beats compared, %0d mismatches.", pixels_checked, error_count);
        if (error_count == 0 && pending_pixels == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
